>>> sv/qsed_pkg.sv
// Shared types, codes and helper functions of the quoted string escape decoder.
`timescale 1ns / 1ps
package qsed_pkg;

  // Decoder modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_VERB = 3'd1;
  localparam logic [2:0] MODE_STR  = 3'd2;
  localparam logic [2:0] MODE_ESC  = 3'd3;
  localparam logic [2:0] MODE_OCT  = 3'd4;
  localparam logic [2:0] MODE_HEX  = 3'd5;
  localparam logic [2:0] MODE_UNI  = 3'd6;

  // Result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_END    = 3'd1;
  localparam logic [2:0] ST_UNTERM = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_BADUNI = 3'd4;
  localparam logic [2:0] ST_BADESC = 3'd5;
  localparam logic [2:0] ST_NOTSTR = 3'd6;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // Result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic [2:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  cnt;
    logic [15:0] acc;
  } st_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_t;

  // Outcome of an ordinary byte inside an escaped string
  typedef struct packed {
    logic [2:0] mode;
    logic       has;
    res_t       res;
  } sb_t;

  function automatic res_t mk_res(input logic [7:0] data, input logic vld,
                                  input logic [2:0] status);
    res_t r;
    r.data   = data;
    r.vld    = vld;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

  // {ok, value} of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic sb_t string_byte(input logic [7:0] c);
    sb_t s;
    s.mode = MODE_STR;
    s.has  = 1'b1;
    s.res  = mk_res(c, 1'b1, ST_DATA);
    case (c)
      CH_DQUOT: begin
        s.mode = MODE_IDLE;
        s.res  = mk_res(8'd0, 1'b0, ST_END);
      end
      CH_BSL: begin
        s.mode = MODE_ESC;
        s.has  = 1'b0;
        s.res  = mk_res(8'd0, 1'b0, ST_DATA);
      end
      CH_NUL: begin
        s.mode = MODE_IDLE;
        s.res  = mk_res(8'd0, 1'b0, ST_UNTERM);
      end
      default: ;
    endcase
    return s;
  endfunction

endpackage

>>> sv/quoted_string_escape_decoder_top.sv
// Top level of the quoted string escape decoder.
`timescale 1ns / 1ps
// Decodes C-like string literals one source byte per beat. In idle, an
// apostrophe opens a verbatim string and a double quote opens an escaped
// string; any other byte answers with a not-a-string status. Escapes cover
// a b f n r t (either case), quote, apostrophe, backslash, one to three
// octal digits, \x with two hex digits and \u with four. Each input beat
// produces zero, one or two result beats; out_last marks the final result
// of its input byte. Rate: one input byte per cycle while in_stall is low.
// Each byte passes an input register, one level of decode logic and lands
// in a four-entry result queue. The queue drains one result per cycle while
// out_stall is low: only a \u escape above 0xFF or a byte other than a
// backslash that ends a short octal escape yields two results. Input is
// stalled while a byte waits in the input register and the queue lacks
// room for two results; neither stall depends on the other side's stall
// within the same cycle.
module quoted_string_escape_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic [2:0] out_status,
  output logic       out_last
);
  import qsed_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  st_t        st_r;
  st_t        st_nxt;
  dec_t       dec;
  logic       proc_go;
  logic       in_take;
  logic       q_room2;
  logic       q_not_empty;
  res_t       q_head;
  logic [QAw:0] q_count;

  // Decode the held byte only when the queue can absorb two results.
  assign proc_go    = in_vld_r & q_room2;
  // Hold the input while a byte waits in the input register and the queue lacks room for two results.
  assign in_stall   = in_vld_r & ~q_room2;
  assign in_take    = in_valid & ~in_stall;
  assign in_vld_nxt = in_take | (in_vld_r & ~proc_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '{mode: MODE_IDLE, cnt: 2'd0, acc: 16'd0};
    end else begin
      in_vld_r <= in_vld_nxt;
      if (proc_go) st_r <= st_nxt;
    end
  end

  // Payload register: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_byte;
  end

  qsed_decode u_decode (
    .c      (in_byte_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .dec    (dec)
  );

  qsed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (proc_go),
    .dec       (dec),
    .pop       (q_not_empty & ~out_stall),
    .head      (q_head),
    .not_empty (q_not_empty),
    .room2     (q_room2),
    .count     (q_count)
  );

  assign out_valid      = q_not_empty;
  assign out_byte       = q_head.data;
  assign out_byte_valid = q_head.vld;
  assign out_status     = q_head.status;
  assign out_last       = q_head.last;

`ifndef ASSERT_OFF
  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (QAw+1)'(QDepth))
    else $error("result queue overfilled");

  // A byte blocked in the input register stays there unchanged.
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc_go |=> in_vld_r && $stable(in_byte_r))
    else $error("held input byte lost or changed");

  // With two results only the second closes the byte.
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && dec.n == 2'd2 |-> !dec.r0.last && dec.r1.last)
    else $error("last flag misplaced on a result pair");

  // Decoder state stays put when no byte is decoded.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !proc_go |=> $stable(st_r))
    else $error("decoder state moved without a byte");
`endif

endmodule

>>> sv/qsed_decode.sv
// Next-state and result logic for one source byte.
`timescale 1ns / 1ps
module qsed_decode (
  input  logic [7:0]   c,
  input  qsed_pkg::st_t st,
  output qsed_pkg::st_t st_nxt,
  output qsed_pkg::dec_t dec
);
  import qsed_pkg::*;

  logic [7:0]  lc;
  logic [4:0]  hx;
  logic [15:0] acc_hex;
  logic [15:0] acc_oct;
  logic [1:0]  cnt_inc;
  sb_t         sb;

  assign lc      = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign hx      = hex_digit(c);
  assign acc_hex = {st.acc[11:0], hx[3:0]};
  assign acc_oct = {st.acc[12:0], c[2:0]};
  assign cnt_inc = st.cnt + 2'd1;
  assign sb      = string_byte(c);

  always_comb begin
    st_nxt = st;
    dec.n  = 2'd0;
    dec.r0 = mk_res(8'd0, 1'b0, ST_DATA);
    dec.r1 = mk_res(8'd0, 1'b0, ST_DATA);
    case (st.mode)
      MODE_IDLE: begin
        if (c == CH_APOS) st_nxt.mode = MODE_VERB;
        else if (c == CH_DQUOT) st_nxt.mode = MODE_STR;
        else begin
          dec.n  = 2'd1;
          dec.r0 = mk_res(8'd0, 1'b0, ST_NOTSTR);
        end
      end
      MODE_VERB: begin
        dec.n = 2'd1;
        if (c == CH_APOS) begin
          st_nxt.mode = MODE_IDLE;
          dec.r0      = mk_res(8'd0, 1'b0, ST_END);
        end else if (c == CH_NUL) begin
          st_nxt.mode = MODE_IDLE;
          dec.r0      = mk_res(8'd0, 1'b0, ST_UNTERM);
        end else begin
          dec.r0 = mk_res(c, 1'b1, ST_DATA);
        end
      end
      MODE_STR: begin
        st_nxt.mode = sb.mode;
        dec.n       = {1'b0, sb.has};
        dec.r0      = sb.res;
      end
      MODE_ESC: begin
        st_nxt.mode = MODE_STR;
        dec.n       = 2'd1;
        case (lc)
          "a":      dec.r0 = mk_res(8'd7, 1'b1, ST_DATA);
          "b":      dec.r0 = mk_res(8'd8, 1'b1, ST_DATA);
          "f":      dec.r0 = mk_res(8'd12, 1'b1, ST_DATA);
          "n":      dec.r0 = mk_res(8'd10, 1'b1, ST_DATA);
          "r":      dec.r0 = mk_res(8'd13, 1'b1, ST_DATA);
          "t":      dec.r0 = mk_res(8'd9, 1'b1, ST_DATA);
          CH_DQUOT, CH_APOS, CH_BSL: dec.r0 = mk_res(c, 1'b1, ST_DATA);
          "x": begin
            st_nxt = '{mode: MODE_HEX, cnt: 2'd0, acc: 16'd0};
            dec.n  = 2'd0;
          end
          "u": begin
            st_nxt = '{mode: MODE_UNI, cnt: 2'd0, acc: 16'd0};
            dec.n  = 2'd0;
          end
          CH_NUL: begin
            st_nxt.mode = MODE_IDLE;
            dec.r0      = mk_res(8'd0, 1'b0, ST_UNTERM);
          end
          default: begin
            if (c >= "0" && c <= "7") begin
              st_nxt = '{mode: MODE_OCT, cnt: 2'd1, acc: {13'd0, c[2:0]}};
              dec.n  = 2'd0;
            end else begin
              st_nxt.mode = MODE_IDLE;
              dec.r0      = mk_res(8'd0, 1'b0, ST_BADESC);
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (c >= "0" && c <= "7" && st.cnt != 2'd3) begin
          st_nxt.acc = acc_oct;
          st_nxt.cnt = cnt_inc;
          if (cnt_inc == 2'd3) begin
            st_nxt.mode = MODE_STR;
            st_nxt.cnt  = 2'd0;
            dec.n       = 2'd1;
            dec.r0      = mk_res(acc_oct[7:0], 1'b1, ST_DATA);
          end
        end else begin
          // flush the short escape, then treat the byte as string data
          st_nxt.cnt  = 2'd0;
          st_nxt.mode = sb.mode;
          dec.r0      = mk_res(st.acc[7:0], 1'b1, ST_DATA);
          dec.r1      = sb.res;
          dec.n       = sb.has ? 2'd2 : 2'd1;
        end
      end
      MODE_HEX: begin
        dec.n = 2'd1;
        if (!hx[4]) begin
          st_nxt.mode = MODE_IDLE;
          st_nxt.cnt  = 2'd0;
          dec.r0      = mk_res(8'd0, 1'b0, ST_BADHEX);
        end else begin
          st_nxt.acc = acc_hex;
          st_nxt.cnt = cnt_inc;
          if (cnt_inc == 2'd2) begin
            st_nxt.mode = MODE_STR;
            st_nxt.cnt  = 2'd0;
            dec.r0      = mk_res(acc_hex[7:0], 1'b1, ST_DATA);
          end else begin
            dec.n = 2'd0;
          end
        end
      end
      MODE_UNI: begin
        dec.n = 2'd1;
        if (!hx[4]) begin
          st_nxt.mode = MODE_IDLE;
          st_nxt.cnt  = 2'd0;
          dec.r0      = mk_res(8'd0, 1'b0, ST_BADUNI);
        end else begin
          st_nxt.acc = acc_hex;
          if (st.cnt == 2'd3) begin
            st_nxt.mode = MODE_STR;
            st_nxt.cnt  = 2'd0;
            if (acc_hex[15:8] == 8'd0) begin
              dec.r0 = mk_res(acc_hex[7:0], 1'b1, ST_DATA);
            end else begin
              dec.n  = 2'd2;
              dec.r0 = mk_res(acc_hex[15:8], 1'b1, ST_DATA);
              dec.r1 = mk_res(acc_hex[7:0], 1'b1, ST_DATA);
            end
          end else begin
            st_nxt.cnt = cnt_inc;
            dec.n      = 2'd0;
          end
        end
      end
      default: begin
        st_nxt = '{mode: MODE_IDLE, cnt: 2'd0, acc: 16'd0};
        dec.n  = 2'd1;
        dec.r0 = mk_res(8'd0, 1'b0, ST_NOTSTR);
      end
    endcase
    // mark the final result of this byte
    if (dec.n == 2'd1) dec.r0.last = 1'b1;
    if (dec.n == 2'd2) dec.r1.last = 1'b1;
  end

endmodule

>>> sv/qsed_queue.sv
// Result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
module qsed_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qsed_pkg::dec_t dec,
  input  logic           pop,
  output qsed_pkg::res_t head,
  output logic           not_empty,
  output logic           room2,
  output logic [$clog2(qsed_pkg::QDepth):0] count
);
  import qsed_pkg::*;

  res_t           mem_r [QDepth];
  logic [QAw-1:0] wr_r, wr_nxt;
  logic [QAw-1:0] rd_r, rd_nxt;
  logic [QAw:0]   cnt_r, cnt_nxt;
  logic [1:0]     n_push;
  logic [QAw-1:0] wr_p1;

  assign n_push    = push ? dec.n : 2'd0;
  assign wr_p1     = wr_r + QAw'(1);
  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= (QAw+1)'(QDepth - 2));
  assign count     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + QAw'(n_push);
    rd_nxt  = pop ? rd_r + QAw'(1) : rd_r;
    cnt_nxt = cnt_r + (QAw+1)'(n_push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r] <= dec.r0;
    if (n_push == 2'd2) mem_r[wr_p1] <= dec.r1;
  end

endmodule

>>> tb/decode_checker.sv
// Checker for the quoted string escape decoder: predicts result beats and compares them.
`timescale 1ns / 1ps
module decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic [2:0] out_status,
  input  logic       out_last,
  output int         errors,
  output int         pending,
  output int         results_checked,
  output int         double_bytes,
  output logic [7:0] status_seen
);
  import qsed_pkg::*;

  res_t        expected_q[$];
  res_t        step_q[$];
  logic [2:0]  dec_mode;
  logic [1:0]  digit_cnt;
  logic [15:0] accum;

  function automatic void emit(input logic [7:0] b, input logic v, input logic [2:0] s);
    res_t r;
    r.data   = b;
    r.vld    = v;
    r.status = s;
    r.last   = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic int nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // ordinary byte inside an escaped string
  function automatic void plain_byte(input logic [7:0] c);
    case (c)
      CH_DQUOT: begin
        dec_mode = MODE_IDLE;
        emit(8'd0, 1'b0, ST_END);
      end
      CH_BSL: dec_mode = MODE_ESC;
      CH_NUL: begin
        dec_mode = MODE_IDLE;
        emit(8'd0, 1'b0, ST_UNTERM);
      end
      default: begin
        dec_mode = MODE_STR;
        emit(c, 1'b1, ST_DATA);
      end
    endcase
  endfunction

  function automatic void escape_byte(input logic [7:0] c);
    logic [7:0] folded;
    folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    dec_mode = MODE_STR;
    case (folded)
      "a": emit(8'd7, 1'b1, ST_DATA);
      "b": emit(8'd8, 1'b1, ST_DATA);
      "f": emit(8'd12, 1'b1, ST_DATA);
      "n": emit(8'd10, 1'b1, ST_DATA);
      "r": emit(8'd13, 1'b1, ST_DATA);
      "t": emit(8'd9, 1'b1, ST_DATA);
      CH_DQUOT, CH_APOS, CH_BSL: emit(c, 1'b1, ST_DATA);
      "x": begin
        dec_mode  = MODE_HEX;
        digit_cnt = 2'd0;
        accum     = 16'd0;
      end
      "u": begin
        dec_mode  = MODE_UNI;
        digit_cnt = 2'd0;
        accum     = 16'd0;
      end
      CH_NUL: begin
        dec_mode = MODE_IDLE;
        emit(8'd0, 1'b0, ST_UNTERM);
      end
      default: begin
        if (c >= "0" && c <= "7") begin
          dec_mode  = MODE_OCT;
          digit_cnt = 2'd1;
          accum     = 16'(c - "0");
        end else begin
          dec_mode = MODE_IDLE;
          emit(8'd0, 1'b0, ST_BADESC);
        end
      end
    endcase
  endfunction

  // work out the result beats of one input byte into step_q
  function automatic void decode_byte(input logic [7:0] c);
    int nib;
    step_q.delete();
    case (dec_mode)
      MODE_IDLE: begin
        if (c == CH_APOS) dec_mode = MODE_VERB;
        else if (c == CH_DQUOT) dec_mode = MODE_STR;
        else emit(8'd0, 1'b0, ST_NOTSTR);
      end
      MODE_VERB: begin
        if (c == CH_APOS) begin
          dec_mode = MODE_IDLE;
          emit(8'd0, 1'b0, ST_END);
        end else if (c == CH_NUL) begin
          dec_mode = MODE_IDLE;
          emit(8'd0, 1'b0, ST_UNTERM);
        end else begin
          emit(c, 1'b1, ST_DATA);
        end
      end
      MODE_STR: plain_byte(c);
      MODE_ESC: escape_byte(c);
      MODE_OCT: begin
        if (c >= "0" && c <= "7" && digit_cnt < 2'd3) begin
          accum     = accum * 16'd8 + 16'(c - "0");
          digit_cnt = digit_cnt + 2'd1;
          if (digit_cnt == 2'd3) begin
            dec_mode  = MODE_STR;
            digit_cnt = 2'd0;
            emit(accum[7:0], 1'b1, ST_DATA);
          end
        end else begin
          // short escape: flush its value, then treat the byte as string data
          emit(accum[7:0], 1'b1, ST_DATA);
          digit_cnt = 2'd0;
          plain_byte(c);
        end
      end
      MODE_HEX: begin
        nib = nibble(c);
        if (nib < 0) begin
          dec_mode  = MODE_IDLE;
          digit_cnt = 2'd0;
          emit(8'd0, 1'b0, ST_BADHEX);
        end else begin
          accum     = {accum[11:0], 4'(nib)};
          digit_cnt = digit_cnt + 2'd1;
          if (digit_cnt == 2'd2) begin
            dec_mode  = MODE_STR;
            digit_cnt = 2'd0;
            emit(accum[7:0], 1'b1, ST_DATA);
          end
        end
      end
      MODE_UNI: begin
        nib = nibble(c);
        if (nib < 0) begin
          dec_mode  = MODE_IDLE;
          digit_cnt = 2'd0;
          emit(8'd0, 1'b0, ST_BADUNI);
        end else begin
          accum = {accum[11:0], 4'(nib)};
          if (digit_cnt == 2'd3) begin
            dec_mode  = MODE_STR;
            digit_cnt = 2'd0;
            if (accum <= 16'h00FF) begin
              emit(accum[7:0], 1'b1, ST_DATA);
            end else begin
              emit(accum[15:8], 1'b1, ST_DATA);
              emit(accum[7:0], 1'b1, ST_DATA);
            end
          end else begin
            digit_cnt = digit_cnt + 2'd1;
          end
        end
      end
      default: begin
        dec_mode  = MODE_IDLE;
        digit_cnt = 2'd0;
        accum     = 16'd0;
        emit(8'd0, 1'b0, ST_NOTSTR);
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      dec_mode  = MODE_IDLE;
      digit_cnt = 2'd0;
      accum     = 16'd0;
      expected_q.delete();
      errors          = 0;
      results_checked = 0;
      double_bytes    = 0;
      status_seen     = 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        if (step_q.size() == 2) double_bytes++;
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        status_seen[out_status] = 1'b1;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual byte %0h valid %b status %0d last %b",
                   $time, out_byte, out_byte_valid, out_status, out_last);
        end else begin
          want = expected_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_byte_valid", 8'(want.vld), 8'(out_byte_valid));
          check_field("out_status", 8'(want.status), 8'(out_status));
          check_field("out_last", 8'(want.last), 8'(out_last));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/testbench.sv
// Testbench top: drives source bytes into the escape decoder and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import qsed_pkg::*;

  // Cycles without any accepted beat on either channel before giving up
  localparam int IdleLimit = 5000;
  // Input beats to send in the random part
  localparam int RandomBeats = 500;
  // Spacing of the full drains during the random part
  localparam int DrainEvery = 150;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic [2:0] out_status;
  logic       out_last;

  int         errors;
  int         pending;
  int         results_checked;
  int         double_bytes;
  logic [7:0] status_seen;

  // Bytes of the sequence under construction, sent as a unit
  logic [7:0] seq[$];
  int         sent       = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         stall_cycle = 0;
  stall_style_t stall_style = STALL_NONE;

  // Escape letters in lower case; quote, apostrophe and backslash stand for themselves
  logic [7:0] esc_letters[9] = '{"a", "b", "f", "n", "r", "t", CH_DQUOT, CH_APOS, CH_BSL};

  always #10 clk = ~clk;

  quoted_string_escape_decoder_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  decode_checker dec_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_status      (out_status),
    .out_last        (out_last),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked),
    .double_bytes    (double_bytes),
    .status_seen     (status_seen)
  );

  // Receiver stall: switch style at random between no stall, random
  // stalls and a fixed on/off rhythm, so stalls land on every decode phase.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) stall_style <= stall_style_t'($urandom_range(0, 2));
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= (stall_cycle % 9) < 4;
    endcase
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hex digit character of v, letters in random case
  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(0, 1) == 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  // Random nonzero string byte other than the closing quote; inside an
  // escaped string also avoid the backslash
  function automatic logic [7:0] pick_plain(input logic [7:0] close_ch);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == close_ch || (close_ch == CH_DQUOT && b == CH_BSL));
    return b;
  endfunction

  // Drive one beat and hold it until accepted. Bursts of random length are
  // separated by random gaps; a zero gap keeps valid high across bursts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_seq;
    foreach (seq[i]) send_byte(seq[i]);
    seq.delete();
  endtask

  // Drop valid and hold off until every expected result has come back.
  // Sample the pending count at the falling edge to stay clear of the
  // checker's update at the rising edge.
  task automatic wait_drained;
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Well-formed escaped string with random content: plain bytes, letter
  // escapes, octal, \x and \u escapes; \u values are about half above 0xFF.
  task automatic add_escaped_string;
    int units;
    int k;
    units = $urandom_range(0, 8);
    seq.push_back(CH_DQUOT);
    repeat (units) begin
      case ($urandom_range(0, 5))
        0, 1: seq.push_back(pick_plain(CH_DQUOT));
        2: begin
          k = $urandom_range(0, 8);
          seq.push_back(CH_BSL);
          if (k < 6 && $urandom_range(0, 1) == 1) seq.push_back(esc_letters[k] - 8'd32);
          else seq.push_back(esc_letters[k]);
        end
        3: begin
          seq.push_back(CH_BSL);
          repeat ($urandom_range(1, 3)) seq.push_back(8'("0" + $urandom_range(0, 7)));
        end
        4: begin
          seq.push_back(CH_BSL);
          seq.push_back(($urandom_range(0, 1) == 1) ? "x" : "X");
          repeat (2) seq.push_back(hex_char($urandom_range(0, 15)));
        end
        default: begin
          seq.push_back(CH_BSL);
          seq.push_back(($urandom_range(0, 1) == 1) ? "u" : "U");
          if ($urandom_range(0, 1) == 1) begin
            repeat (2) seq.push_back("0");
          end else begin
            repeat (2) seq.push_back(hex_char($urandom_range(0, 15)));
          end
          repeat (2) seq.push_back(hex_char($urandom_range(0, 15)));
        end
      endcase
    end
    seq.push_back(CH_DQUOT);
  endtask

  // Break the pending sequence: cut it short and end on a zero or any byte
  task automatic break_seq;
    int cut;
    cut = $urandom_range(1, seq.size() - 1);
    seq = seq[0:cut-1];
    seq.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int pick;
    int next_drain;

    // Hold reset, then release it once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: not-a-string bytes in idle (zero included), a verbatim
    // string with high bytes, then one escaped string with a letter escape
    // in upper case, a \u above 0xFF, a full octal escape, short
    // octal escapes ended by a letter, by a backslash and by the closing
    // quote, and a high data byte. Errors follow: bad hex digit, bad escape
    // on a high byte, end of input after a backslash and inside a string.
    seq = '{"A", CH_NUL,
            CH_APOS, 8'hFF, 8'h80, CH_APOS,
            CH_DQUOT, CH_BSL, "A", CH_BSL, "u", "1", "2", "a", "B",
            CH_BSL, "3", "7", "7", CH_BSL, "1", "x", CH_BSL, "7", CH_BSL, CH_DQUOT,
            8'hE9, CH_BSL, "5", CH_DQUOT,
            CH_DQUOT, CH_BSL, "x", "G",
            CH_DQUOT, CH_BSL, 8'hE9,
            CH_DQUOT, CH_BSL, CH_NUL,
            CH_DQUOT, CH_NUL};
    send_seq();

    // Let the directed results drain before random traffic starts
    wait_drained();

    // Random part: mostly well-formed escaped strings, some broken ones,
    // verbatim strings and raw noise that hits the idle state
    sent = 0;
    next_drain = DrainEvery;
    while (sent < RandomBeats) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_escaped_string();
        if ($urandom_range(0, 3) == 0) break_seq();
      end else if (pick < 8) begin
        seq.push_back(CH_APOS);
        repeat ($urandom_range(0, 6)) seq.push_back(pick_plain(CH_APOS));
        seq.push_back(($urandom_range(0, 5) == 0) ? CH_NUL : CH_APOS);
      end else begin
        repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
      end
      send_seq();
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DrainEvery;
      end
    end

    // Drain, then allow time for any stray result beat
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d random beats after the directed set; checked %0d results.",
             sent, results_checked);
    $display("Input bytes with two results: %0d; status codes seen (bit per code): %b",
             double_bytes, status_seen);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> quoted_string_escape_decoder_top.f
sv/qsed_pkg.sv
sv/qsed_decode.sv
sv/qsed_queue.sv
sv/quoted_string_escape_decoder_top.sv
tb/decode_checker.sv
tb/testbench.sv
